### rtl/core/rcdp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcdp_pkg
// Shared types and constants for the range-checked decimal parser.
// ----------------------------------------------------------------------------
package rcdp_pkg;

  localparam int VALUE_BITS = 32;
  localparam int MAX_BITS   = VALUE_BITS - 1;
  // Magnitude of the most negative value needs the full word, unsigned.
  localparam int ACC_BITS   = VALUE_BITS;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] U8_C2    = 8'hC2;
  localparam logic [7:0] U8_85    = 8'h85;
  localparam logic [7:0] U8_A0    = 8'hA0;
  localparam logic [7:0] U8_E1    = 8'hE1;
  localparam logic [7:0] U8_9A    = 8'h9A;
  localparam logic [7:0] U8_E2    = 8'hE2;
  localparam logic [7:0] U8_E3    = 8'hE3;
  localparam logic [7:0] U8_80    = 8'h80;
  localparam logic [7:0] U8_81    = 8'h81;
  localparam logic [7:0] U8_8A    = 8'h8A;
  localparam logic [7:0] U8_A8    = 8'hA8;
  localparam logic [7:0] U8_A9    = 8'hA9;
  localparam logic [7:0] U8_AF    = 8'hAF;
  localparam logic [7:0] U8_9F    = 8'h9F;

  localparam logic CFG_MIN_VALUE = 1'b0;
  localparam logic CFG_MAX_VALUE = 1'b1;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_SIGN,
    PH_DIGITS,
    PH_TRAIL_WS,
    PH_TRAIL_NUL,
    PH_FAIL
  } phase_t;

  typedef struct packed {
    phase_t              phase;
    logic [15:0]         pend_bytes;
    logic [1:0]          pend_cnt;
    logic                neg;
    logic [ACC_BITS-1:0] acc;
  } parse_st_t;

  localparam parse_st_t ST_CLEAR = '{phase: PH_LEAD, pend_bytes: 16'h0000,
                                     pend_cnt: 2'd0, neg: 1'b0,
                                     acc: {ACC_BITS{1'b0}}};

endpackage

### rtl/core/rcdp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcdp_step
// Next-state logic of the parser for one text byte: whitespace skipping,
// UTF-8 space sequences, sign, digit accumulation with overflow check and
// trailing whitespace and NUL padding.
// ----------------------------------------------------------------------------
module rcdp_step (
  input  rcdp_pkg::parse_st_t                 st,
  input  logic [7:0]                          text_byte,
  input  logic signed [rcdp_pkg::VALUE_BITS-1:0] min_value,
  input  logic [rcdp_pkg::MAX_BITS-1:0]       max_value,
  output rcdp_pkg::parse_st_t                 st_nxt
);

  localparam int PROD_BITS = rcdp_pkg::ACC_BITS + 4;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == rcdp_pkg::CH_SPACE) ||
           (b >= rcdp_pkg::CH_TAB && b <= rcdp_pkg::CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= rcdp_pkg::CH_ZERO) && (b <= rcdp_pkg::CH_NINE);
  endfunction

  logic [rcdp_pkg::ACC_BITS-1:0]  limit;
  logic [rcdp_pkg::VALUE_BITS:0]  neg_min;
  logic [3:0]                     digit;
  logic [PROD_BITS-1:0]           prod;
  logic                           digit_fits;
  logic [7:0]                     p0;
  logic [7:0]                     p1;
  logic                           seq_ok;

  // Ten times the magnitude plus the digit must stay within the limit.
  always_comb begin
    neg_min = -{min_value[rcdp_pkg::VALUE_BITS-1], min_value};
    if (st.neg && min_value[rcdp_pkg::VALUE_BITS-1]) begin
      limit = neg_min[rcdp_pkg::ACC_BITS-1:0];
    end else begin
      limit = {1'b0, max_value};
    end
    digit = text_byte[3:0] - rcdp_pkg::CH_ZERO[3:0];
    prod  = {1'b0, st.acc, 3'b000} + {3'b000, st.acc, 1'b0}
          + {{(PROD_BITS-4){1'b0}}, digit};
    digit_fits = (prod <= {4'b0000, limit});
  end

  always_comb begin
    p0     = st.pend_bytes[7:0];
    p1     = st.pend_bytes[15:8];
    seq_ok = 1'b0;
    st_nxt = st;
    case (st.phase)
      rcdp_pkg::PH_LEAD: begin
        if (st.pend_cnt == 2'd1) begin
          if (p0 == rcdp_pkg::U8_C2) begin
            seq_ok = (text_byte == rcdp_pkg::U8_85) || (text_byte == rcdp_pkg::U8_A0);
            st_nxt.pend_cnt   = 2'd0;
            st_nxt.pend_bytes = 16'h0000;
            if (!seq_ok) st_nxt.phase = rcdp_pkg::PH_FAIL;
          end else begin
            seq_ok = (p0 == rcdp_pkg::U8_E1 && text_byte == rcdp_pkg::U8_9A) ||
                     (p0 == rcdp_pkg::U8_E2 && (text_byte == rcdp_pkg::U8_80 ||
                                                text_byte == rcdp_pkg::U8_81)) ||
                     (p0 == rcdp_pkg::U8_E3 && text_byte == rcdp_pkg::U8_80);
            if (seq_ok) begin
              st_nxt.pend_bytes = {text_byte, p0};
              st_nxt.pend_cnt   = 2'd2;
            end else begin
              st_nxt.phase = rcdp_pkg::PH_FAIL;
            end
          end
        end else if (st.pend_cnt != 2'd0) begin
          seq_ok = (p0 == rcdp_pkg::U8_E1 && p1 == rcdp_pkg::U8_9A &&
                    text_byte == rcdp_pkg::U8_80) ||
                   (p0 == rcdp_pkg::U8_E2 && p1 == rcdp_pkg::U8_80 &&
                    ((text_byte >= rcdp_pkg::U8_80 && text_byte <= rcdp_pkg::U8_8A) ||
                     text_byte == rcdp_pkg::U8_A8 || text_byte == rcdp_pkg::U8_A9 ||
                     text_byte == rcdp_pkg::U8_AF)) ||
                   (p0 == rcdp_pkg::U8_E2 && p1 == rcdp_pkg::U8_81 &&
                    text_byte == rcdp_pkg::U8_9F) ||
                   (p0 == rcdp_pkg::U8_E3 && p1 == rcdp_pkg::U8_80 &&
                    text_byte == rcdp_pkg::U8_80);
          st_nxt.pend_cnt   = 2'd0;
          st_nxt.pend_bytes = 16'h0000;
          if (!seq_ok) st_nxt.phase = rcdp_pkg::PH_FAIL;
        end else if (is_ws(text_byte)) begin
          st_nxt = st;
        end else if (text_byte == rcdp_pkg::U8_C2 || text_byte == rcdp_pkg::U8_E1 ||
                     text_byte == rcdp_pkg::U8_E2 || text_byte == rcdp_pkg::U8_E3) begin
          st_nxt.pend_bytes = {8'h00, text_byte};
          st_nxt.pend_cnt   = 2'd1;
        end else if (text_byte == rcdp_pkg::CH_PLUS || text_byte == rcdp_pkg::CH_MINUS) begin
          st_nxt.neg   = (text_byte == rcdp_pkg::CH_MINUS);
          st_nxt.phase = rcdp_pkg::PH_SIGN;
        end else if (is_digit(text_byte)) begin
          if (digit_fits) begin
            st_nxt.acc   = prod[rcdp_pkg::ACC_BITS-1:0];
            st_nxt.phase = rcdp_pkg::PH_DIGITS;
          end else begin
            st_nxt.phase = rcdp_pkg::PH_FAIL;
          end
        end else begin
          st_nxt.phase = rcdp_pkg::PH_FAIL;
        end
      end
      rcdp_pkg::PH_SIGN, rcdp_pkg::PH_DIGITS: begin
        if (is_digit(text_byte)) begin
          if (digit_fits) begin
            st_nxt.acc   = prod[rcdp_pkg::ACC_BITS-1:0];
            st_nxt.phase = rcdp_pkg::PH_DIGITS;
          end else begin
            st_nxt.phase = rcdp_pkg::PH_FAIL;
          end
        end else if (st.phase == rcdp_pkg::PH_SIGN) begin
          st_nxt.phase = rcdp_pkg::PH_FAIL;
        end else if (is_ws(text_byte)) begin
          st_nxt.phase = rcdp_pkg::PH_TRAIL_WS;
        end else if (text_byte == rcdp_pkg::CH_NUL) begin
          st_nxt.phase = rcdp_pkg::PH_TRAIL_NUL;
        end else begin
          st_nxt.phase = rcdp_pkg::PH_FAIL;
        end
      end
      rcdp_pkg::PH_TRAIL_WS: begin
        if (text_byte == rcdp_pkg::CH_NUL) begin
          st_nxt.phase = rcdp_pkg::PH_TRAIL_NUL;
        end else if (!is_ws(text_byte)) begin
          st_nxt.phase = rcdp_pkg::PH_FAIL;
        end
      end
      rcdp_pkg::PH_TRAIL_NUL: begin
        if (text_byte != rcdp_pkg::CH_NUL) st_nxt.phase = rcdp_pkg::PH_FAIL;
      end
      default: begin
        st_nxt.phase = rcdp_pkg::PH_FAIL;
      end
    endcase
  end

endmodule

### rtl/core/range_checked_decimal_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_checked_decimal_parser
// Parses a decimal integer from a byte stream and checks it against the
// configured minimum and maximum; one result per text.
// ----------------------------------------------------------------------------
//  channel  direction  tdata                 tuser       tlast
//  in_      slave      [7:0] text_byte       empty_text  last_byte
//  out_     master     [31:0] parsed_value   parse_ok    -
//  cfg_     slave      index 0 min, 1 max    -           -
//
// One byte is accepted per cycle while no stalled result holds the pipeline.
// A byte is registered in the input register, then the parser state and,
// at the end of a text, the result register are updated from it.
// A stalled result holds the byte pipeline, and the input register then fills
// only if empty. Reset returns the parser to the leading whitespace phase and
// the registers to the full signed range. cfg_ready is always high.
// ----------------------------------------------------------------------------
module range_checked_decimal_parser (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] text_byte
  input  logic                              in_tlast,   // last_byte
  input  logic                              in_tuser,   // empty_text
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rcdp_pkg::VALUE_BITS-1:0]   out_tdata,  // [31:0] parsed_value
  output logic                              out_tuser,  // parse_ok
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [rcdp_pkg::VALUE_BITS-1:0]   cfg_data
);

  localparam int VB = rcdp_pkg::VALUE_BITS;

  logic signed [VB-1:0]             min_r;
  logic [rcdp_pkg::MAX_BITS-1:0]    max_r;
  logic                             s1_valid_r;
  logic [7:0]                       s1_byte_r;
  logic                             s1_last_r;
  logic                             s1_empty_r;
  rcdp_pkg::parse_st_t              st_r;
  rcdp_pkg::parse_st_t              st_fed;
  rcdp_pkg::parse_st_t              st_end;
  logic                             out_valid_r;
  logic [VB-1:0]                    out_data_r;
  logic                             out_ok_r;
  logic                             adv;
  logic                             ends;
  logic signed [VB:0]               res;
  logic signed [VB:0]               min_x;
  logic signed [VB:0]               max_x;
  logic                             phase_ok;
  logic                             ok;

  assign cfg_ready  = 1'b1;
  assign adv        = !out_valid_r || out_tready;
  assign in_tready  = !s1_valid_r || adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ok_r;

  rcdp_step u_step (
    .st        (st_r),
    .text_byte (s1_byte_r),
    .min_value (min_r),
    .max_value (max_r),
    .st_nxt    (st_fed)
  );

  // An empty-text request ends the text without feeding its byte.
  always_comb begin
    st_end   = s1_empty_r ? st_r : st_fed;
    ends     = s1_last_r || s1_empty_r;
    res      = st_end.neg ? -$signed({1'b0, st_end.acc}) : $signed({1'b0, st_end.acc});
    min_x    = {min_r[VB-1], min_r};
    max_x    = $signed({2'b00, max_r});
    phase_ok = (st_end.phase == rcdp_pkg::PH_DIGITS) ||
               (st_end.phase == rcdp_pkg::PH_TRAIL_WS) ||
               (st_end.phase == rcdp_pkg::PH_TRAIL_NUL);
    // The bounds test also covers a negative sign against a non-negative
    // minimum and any magnitude beyond the sign's limit.
    ok       = phase_ok && (res >= min_x) && (res <= max_x);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r       <= {1'b1, {(VB-1){1'b0}}};
      max_r       <= {rcdp_pkg::MAX_BITS{1'b1}};
      s1_valid_r  <= 1'b0;
      st_r        <= rcdp_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == rcdp_pkg::CFG_MIN_VALUE) begin
          min_r <= cfg_data;
        end else begin
          max_r <= cfg_data[rcdp_pkg::MAX_BITS-1:0];
        end
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r && ends;
        if (s1_valid_r) begin
          st_r <= ends ? rcdp_pkg::ST_CLEAR : st_fed;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r  <= in_tdata;
      s1_last_r  <= in_tlast;
      s1_empty_r <= in_tuser;
    end
    if (adv && s1_valid_r && ends) begin
      out_ok_r   <= ok;
      out_data_r <= ok ? res[VB-1:0] : {VB{1'b0}};
    end
  end

endmodule
